### hdl/active_slab_epoch_table_macros.svh
// Assertion helpers used by the active_slab_epoch_table module.
`ifndef ACTIVE_SLAB_EPOCH_TABLE_MACROS_SVH
`define ACTIVE_SLAB_EPOCH_TABLE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASET_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Plain invariant checked at every rising clock edge outside reset.
`define ASET_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

### hdl/aset_pkg.sv
// ----------------------------------------------------------------------------
// aset_pkg
// Shared widths, status codes and the table entry layout.
// ----------------------------------------------------------------------------
package aset_pkg;

  localparam int EPOCH_W = 48;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int STAT_W  = 2;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 11'd512;

  typedef enum logic [STAT_W-1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_EXPANDED = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] addr;
    logic [EPOCH_W-1:0] unlink_epoch;
    logic [EPOCH_W-1:0] alloc_epoch;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### hdl/aset_item_if.sv
// ----------------------------------------------------------------------------
// aset_item_if
// Input channel: one slab mark request per transfer.
// ----------------------------------------------------------------------------
interface aset_item_if;
  import aset_pkg::*;

  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] slab_address;
  logic [EPOCH_W-1:0] current_epoch;
  logic [EPOCH_W-1:0] collect_epoch;
  logic               is_remove;
  logic               force_clean;

  modport source (output valid, slab_address, current_epoch, collect_epoch,
                  is_remove, force_clean, input ready);
  modport sink (input valid, slab_address, current_epoch, collect_epoch,
                is_remove, force_clean, output ready);
endinterface

### hdl/aset_result_if.sv
// ----------------------------------------------------------------------------
// aset_result_if
// Output channel: one result per accepted request.
// ----------------------------------------------------------------------------
interface aset_result_if;
  import aset_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  slot_index;
  logic [COUNT_W-1:0] occupied_count;
  logic [COUNT_W-1:0] search_limit;
  logic               cleaned;

  modport source (output valid, status, slot_index, occupied_count,
                  search_limit, cleaned, input ready);
  modport sink (input valid, status, slot_index, occupied_count,
                search_limit, cleaned, output ready);
endinterface

### hdl/aset_ram.sv
// ----------------------------------------------------------------------------
// aset_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module aset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/active_slab_epoch_table.sv
// ----------------------------------------------------------------------------
// active_slab_epoch_table
// Table of active slab addresses with an allocation and unlink epoch each.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel and each produces exactly one transfer
// on the result channel. The cleanup threshold register is written through
// cfg_we / cfg_wdata; the user must do so only while the block is idle, as
// the block does not enforce it. After reset the block sweeps the whole
// table, one entry per cycle, clearing every entry before item.ready rises;
// register writes are taken during the sweep.
// One request at a time is processed. Every pass streams the table RAM, one
// entry per cycle, over n = min(limit, MAX_ENTRIES) entries: an optional
// cleanup pass (S_CLEAN, then S_CEND), the lookup in S_LOOK (it ends early
// on a hit), then placement in S_PLACE, skipped on a hit, and the result
// load in S_FIN. The single read port of the table RAM sets this rate.
// Results sit in an output register; if the receiver stalls, the next
// request is still accepted and worked on, and only its final load waits
// until the pending result is taken.
// ----------------------------------------------------------------------------
module active_slab_epoch_table #(
  parameter int MAX_ENTRIES   = 1024,
  parameter int INITIAL_LIMIT = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [aset_pkg::COUNT_W-1:0] cfg_wdata,
  aset_item_if.sink              item,
  aset_result_if.source          result
);
  import aset_pkg::*;
  `include "active_slab_epoch_table_macros.svh"

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int LIM_W =
    $clog2((MAX_ENTRIES > INITIAL_LIMIT) ? MAX_ENTRIES : INITIAL_LIMIT) + 2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CLEAN, S_CEND, S_LOOK, S_PLACE, S_FIN
  } state_t;

  state_t             state;
  logic [LIM_W-1:0]   ridx;
  logic               pv;
  logic [IDX_W-1:0]   pidx;
  logic               have_free;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   top;
  logic [CNT_W-1:0]   cnt;
  logic [LIM_W-1:0]   limit;
  logic [COUNT_W-1:0] thr;

  logic [EPOCH_W-1:0] a_addr;
  logic [EPOCH_W-1:0] a_now;
  logic [EPOCH_W-1:0] a_collect;
  logic               a_rem;
  logic               a_cleaned;

  status_t            res_status;
  logic [IDX_W-1:0]   res_slot;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  entry_t             e;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [LIM_W-1:0]   n;
  logic [LIM_W:0]     twice;
  logic [LIM_W-1:0]   half;
  logic               stale;
  logic               hit;
  logic               last;
  logic               issue;
  logic               can_grow;

  aset_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ridx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign e        = entry_t'(ram_rdata);
  assign n        = (limit < LIM_W'(MAX_ENTRIES)) ? limit : LIM_W'(MAX_ENTRIES);
  assign twice    = {limit, 1'b0};
  assign half     = limit >> 1;
  assign can_grow = twice < (LIM_W + 1)'(MAX_ENTRIES);
  assign issue    = ridx < n;
  assign last     = LIM_W'(pidx) == (n - LIM_W'(1));
  assign stale    = e.valid &&
                    ((e.unlink_epoch < a_collect) || (e.unlink_epoch == '0)) &&
                    ((e.alloc_epoch < a_now) || (e.alloc_epoch == '0));
  assign hit      = pv && e.valid && (e.addr == a_addr);

  assign item.ready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx;
    ram_wdata = e;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ridx[IDX_W-1:0];
        ram_wdata = '0;
      end
      S_CLEAN: begin
        // A freed entry keeps its address and allocation epoch.
        ram_we                 = pv && stale;
        ram_wdata.valid        = 1'b0;
        ram_wdata.unlink_epoch = '0;
      end
      S_LOOK: begin
        ram_we = hit;
        if (a_rem) begin
          if (e.unlink_epoch < a_now) ram_wdata.unlink_epoch = a_now;
        end else begin
          if (e.alloc_epoch < a_now) ram_wdata.alloc_epoch = a_now;
        end
      end
      S_PLACE: begin
        ram_we                 = have_free || can_grow;
        ram_waddr              = have_free ? free_idx : limit[IDX_W-1:0];
        ram_wdata.valid        = 1'b1;
        ram_wdata.addr         = a_addr;
        ram_wdata.unlink_epoch = a_rem ? a_now : '0;
        ram_wdata.alloc_epoch  = a_rem ? '0 : a_now;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ridx         <= '0;
      pv           <= 1'b0;
      cnt          <= '0;
      limit        <= LIM_W'(INITIAL_LIMIT);
      thr          <= THRESHOLD_RESET;
      result.valid <= 1'b0;
    end else begin
      if (cfg_we) thr <= cfg_wdata;
      // The completion state reloads the output register itself.
      if (result.valid && result.ready && state != S_FIN) result.valid <= 1'b0;

      if (state == S_CLEAN || state == S_LOOK) begin
        if (issue) begin
          pv   <= 1'b1;
          pidx <= ridx[IDX_W-1:0];
          ridx <= ridx + LIM_W'(1);
        end else begin
          pv <= 1'b0;
        end
      end

      case (state)
        S_CLEAR: begin
          ridx <= ridx + LIM_W'(1);
          if (ridx == LIM_W'(MAX_ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          ridx      <= '0;
          pv        <= 1'b0;
          have_free <= 1'b0;
          top       <= '0;
          if (item.valid) begin
            a_addr    <= item.slab_address;
            a_now     <= item.current_epoch;
            a_collect <= item.collect_epoch;
            a_rem     <= item.is_remove;
            if (item.force_clean || (32'(cnt) > 32'(thr))) begin
              a_cleaned <= 1'b1;
              state     <= S_CLEAN;
            end else begin
              a_cleaned <= 1'b0;
              state     <= S_LOOK;
            end
          end
        end
        S_CLEAN: begin
          if (pv) begin
            if (stale && cnt != '0) cnt <= cnt - CNT_W'(1);
            if (e.valid && !stale) top <= pidx;
            if (last) state <= S_CEND;
          end
        end
        S_CEND: begin
          // Shrink when the upper half of the searched range is empty and half > INITIAL_LIMIT.
          if (LIM_W'(top) < half && half > LIM_W'(INITIAL_LIMIT)) limit <= half;
          ridx  <= '0;
          pv    <= 1'b0;
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (hit) begin
            res_status <= ST_UPDATED;
            res_slot   <= pidx;
            state      <= S_FIN;
          end else if (pv) begin
            if (!e.valid && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= pidx;
            end
            if (last) state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (have_free) begin
            cnt        <= cnt + CNT_W'(1);
            res_status <= ST_INSERTED;
            res_slot   <= free_idx;
          end else if (can_grow) begin
            cnt        <= cnt + CNT_W'(1);
            limit      <= twice[LIM_W-1:0];
            res_status <= ST_EXPANDED;
            res_slot   <= limit[IDX_W-1:0];
          end else begin
            res_status <= ST_DROPPED;
            res_slot   <= '0;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.status         <= res_status;
            result.slot_index     <= SLOT_W'(res_slot);
            result.occupied_count <= COUNT_W'(cnt);
            result.search_limit   <= COUNT_W'(limit);
            result.cleaned        <= a_cleaned;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASET_ALWAYS(a_count_bound, (cnt <= CNT_W'(MAX_ENTRIES)), "occupied count beyond table size")
  `ASET_ALWAYS(a_limit_floor, (limit >= LIM_W'(INITIAL_LIMIT)), "search limit below its floor")
  `ASET_ASSERT(a_idle_no_write, (state == S_IDLE), (!ram_we), "table written while idle")
  `ASET_ASSERT(a_result_load, $rose(result.valid), ($past(state == S_FIN)), "result loaded outside completion")

endmodule

### bench/aset_table_checker.sv
// ----------------------------------------------------------------------------
// aset_table_checker
// Watches the item, result and threshold ports of the slab epoch table. It
// keeps its own copy of the table, predicts the outcome of every item
// transfer, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module aset_table_checker
  import aset_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  aset_item_if               item,
  aset_result_if             result,
  output int                 errors,
  output int                 pending,
  output int                 n_results,
  output int                 n_cleans,
  output int                 n_expands,
  output int                 n_drops,
  output int                 n_hits
);

  localparam int TABLE_DEPTH = 1024;
  localparam int START_LIMIT = 16;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] occupied;
    logic [COUNT_W-1:0] limit;
    logic               cleaned;
  } outcome_t;

  logic               used_q   [TABLE_DEPTH];
  logic [EPOCH_W-1:0] addr_q   [TABLE_DEPTH];
  logic [EPOCH_W-1:0] unlink_q [TABLE_DEPTH];
  logic [EPOCH_W-1:0] alloc_q  [TABLE_DEPTH];
  int                 occupied_q;
  int                 limit_q;
  int                 threshold_q;
  outcome_t           expected_q[$];

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on result %0d: %s is %0d, expected %0d", n_results, field, got, want);
    errors++;
  endtask

  function automatic int bound();
    return (limit_q < TABLE_DEPTH) ? limit_q : TABLE_DEPTH;
  endfunction

  function automatic void sweep(input logic [EPOCH_W-1:0] collect,
                                input logic [EPOCH_W-1:0] now);
    int top;
    int n;
    top = 0;
    n = bound();
    for (int i = 0; i < n; i++) begin
      if (used_q[i] && (unlink_q[i] < collect || unlink_q[i] == 0) &&
          (alloc_q[i] < now || alloc_q[i] == 0)) begin
        used_q[i] = 1'b0;
        unlink_q[i] = '0;
        if (occupied_q > 0) occupied_q--;
      end
      if (used_q[i] && i > top) top = i;
    end
    if (top < limit_q / 2 && limit_q / 2 > START_LIMIT) limit_q = limit_q / 2;
  endfunction

  function automatic void store(input int idx, input logic [EPOCH_W-1:0] addr,
                                input logic [EPOCH_W-1:0] now, input logic rem);
    if (!used_q[idx]) occupied_q++;
    used_q[idx] = 1'b1;
    addr_q[idx] = addr;
    unlink_q[idx] = rem ? now : '0;
    alloc_q[idx] = rem ? '0 : now;
  endfunction

  function automatic outcome_t predict_item(input logic [EPOCH_W-1:0] addr,
                                            input logic [EPOCH_W-1:0] now,
                                            input logic [EPOCH_W-1:0] collect,
                                            input logic rem, input logic force_it);
    outcome_t o;
    int n;
    int free_idx;
    bit found;
    o.status = ST_DROPPED;
    o.slot = '0;
    o.cleaned = 1'b0;
    free_idx = -1;
    found = 0;
    if (force_it || occupied_q > threshold_q) begin
      sweep(collect, now);
      o.cleaned = 1'b1;
    end
    n = bound();
    for (int i = 0; i < n && !found; i++) begin
      if (used_q[i] && addr_q[i] == addr) begin
        if (rem) begin
          if (unlink_q[i] < now) unlink_q[i] = now;
        end else begin
          if (alloc_q[i] < now) alloc_q[i] = now;
        end
        found = 1;
        o.status = ST_UPDATED;
        o.slot = i[SLOT_W-1:0];
      end else if (!used_q[i] && free_idx < 0) begin
        free_idx = i;
      end
    end
    if (!found) begin
      if (free_idx >= 0) begin
        store(free_idx, addr, now, rem);
        o.status = ST_INSERTED;
        o.slot = free_idx[SLOT_W-1:0];
      end else if (limit_q * 2 < TABLE_DEPTH) begin
        int old_limit;
        old_limit = limit_q;
        limit_q = limit_q * 2;
        store(old_limit, addr, now, rem);
        o.status = ST_EXPANDED;
        o.slot = old_limit[SLOT_W-1:0];
      end
    end
    o.occupied = occupied_q[COUNT_W-1:0];
    o.limit = limit_q[COUNT_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        used_q[i] = 1'b0;
        unlink_q[i] = '0;
        alloc_q[i] = '0;
        addr_q[i] = '0;
      end
      occupied_q = 0;
      limit_q = START_LIMIT;
      threshold_q = int'(THRESHOLD_RESET);
      expected_q.delete();
      pending = 0;
    end else begin
      if (cfg_we) threshold_q = int'(cfg_wdata);
      if (item.valid && item.ready)
        expected_q.push_back(predict_item(item.slab_address, item.current_epoch,
                                          item.collect_epoch, item.is_remove,
                                          item.force_clean));
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $display("result transfer %0d arrived with nothing expected", n_results);
          errors++;
        end else begin
          outcome_t want;
          want = expected_q.pop_front();
          if (result.status != want.status)
            report_mismatch("status", result.status, want.status);
          if (result.slot_index != want.slot)
            report_mismatch("slot_index", result.slot_index, want.slot);
          if (result.occupied_count != want.occupied)
            report_mismatch("occupied_count", result.occupied_count, want.occupied);
          if (result.search_limit != want.limit)
            report_mismatch("search_limit", result.search_limit, want.limit);
          if (result.cleaned != want.cleaned)
            report_mismatch("cleaned", result.cleaned, want.cleaned);
          if (want.cleaned) n_cleans++;
          if (want.status == ST_EXPANDED) n_expands++;
          if (want.status == ST_DROPPED) n_drops++;
          if (want.status == ST_UPDATED) n_hits++;
        end
        n_results++;
      end
      pending = expected_q.size();
    end
  end

endmodule

### bench/tb_active_slab_epoch_table.sv
// ----------------------------------------------------------------------------
// tb_active_slab_epoch_table
// Drives mark requests into the slab epoch table in bursts while the result
// side stalls on its own pattern. A short directed sequence is followed by a
// table fill past its capacity, a phase that cleans on every item, and a
// long random phase over a small address pool at a middle threshold.
// ----------------------------------------------------------------------------
module tb_active_slab_epoch_table;
  import aset_pkg::*;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 2200;
  localparam int POOL_SIZE = 40;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  int                 errors, pending, n_results, n_cleans, n_expands, n_drops, n_hits;
  int                 cycles = 0;
  int                 burst_left;
  int                 stall_left = 0;
  int                 stall_mode = 0;
  logic [EPOCH_W-1:0] pool [POOL_SIZE];
  logic [EPOCH_W-1:0] epoch_base;

  aset_item_if   item_ch ();
  aset_result_if result_ch ();

  active_slab_epoch_table dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_ch),
    .result   (result_ch)
  );

  aset_table_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_ch),
    .result   (result_ch),
    .errors   (errors),
    .pending  (pending),
    .n_results(n_results),
    .n_cleans (n_cleans),
    .n_expands(n_expands),
    .n_drops  (n_drops),
    .n_hits   (n_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: mode 0 is always ready, mode 1 is ready at random and mostly stalls, mode 2 toggles.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 9) > 6);
      default: result_ch.ready <= ~result_ch.ready;
    endcase
  end

  function automatic logic [EPOCH_W-1:0] rand48();
    return EPOCH_W'({$urandom(), $urandom()});
  endfunction

  task automatic send_item(input logic [EPOCH_W-1:0] addr, input logic [EPOCH_W-1:0] now,
                           input logic [EPOCH_W-1:0] collect, input logic rem,
                           input logic force_it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid <= 1'b1;
    item_ch.slab_address <= addr;
    item_ch.current_epoch <= now;
    item_ch.collect_epoch <= collect;
    item_ch.is_remove <= rem;
    item_ch.force_clean <= force_it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Lets every expected result arrive, then waits out any work still running.
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pool_item(input int force_odds);
    logic [EPOCH_W-1:0] now;
    logic [EPOCH_W-1:0] collect;
    epoch_base = epoch_base + EPOCH_W'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: now = '0;
      1: now = rand48();
      default: now = epoch_base + EPOCH_W'($urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 9))
      0: collect = '0;
      1: collect = '1;
      default: collect = epoch_base - EPOCH_W'($urandom_range(0, 12));
    endcase
    send_item(pool[$urandom_range(0, POOL_SIZE - 1)], now, collect,
              1'($urandom_range(0, 1)), ($urandom_range(1, force_odds) == 1));
  endtask

  initial begin
    burst_left = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.slab_address = '0;
    item_ch.current_epoch = '0;
    item_ch.collect_epoch = '0;
    item_ch.is_remove = 1'b0;
    item_ch.force_clean = 1'b0;
    epoch_base = 48'd1000;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = (i < 4) ? EPOCH_W'(i) : rand48();
    pool[4] = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: hits on both epoch kinds, extreme addresses and epochs, and
    // the all-zero address, which is stored like any other.
    send_item(48'd1, 48'd5, 48'd0, 1'b0, 1'b0);
    send_item(48'd1, 48'd3, 48'd0, 1'b1, 1'b0);
    send_item(48'd1, 48'd9, 48'd0, 1'b1, 1'b0);
    send_item(48'd1, 48'd2, 48'd0, 1'b0, 1'b0);
    send_item('1, '1, '1, 1'b0, 1'b0);
    send_item('0, '0, '0, 1'b0, 1'b0);
    send_item('0, 48'd7, '0, 1'b0, 1'b0);
    send_item(48'h8000_0000_0000, '0, '0, 1'b1, 1'b0);
    send_item(48'h5555_5555_5555, 48'd50, 48'd10, 1'b1, 1'b0);
    send_item(48'hAAAA_AAAA_AAAA, 48'd50, 48'd10, 1'b0, 1'b0);
    send_item(48'd2, 48'd6, 48'd8, 1'b0, 1'b1);
    send_item('1, '1, '1, 1'b1, 1'b1);
    send_item(48'd1, 48'd10, 48'd100, 1'b0, 1'b1);
    for (int i = 0; i < 12; i++)
      send_item(48'h100 + EPOCH_W'(i), 48'd20, 48'd0, i[0], 1'b0);
    settle();

    // Fill past capacity with cleanup off: expansions up to the largest
    // limit, then drops.
    write_threshold(11'd1024);
    for (int i = 0; i < 530; i++)
      send_item(rand48(), rand48(), rand48(), 1'($urandom_range(0, 1)), 1'b0);
    settle();

    // Cleanup on every item, which frees entries and shrinks the limit.
    write_threshold(11'd0);
    for (int i = 0; i < 200; i++) pool_item(4);
    settle();

    write_threshold(11'd37);
    for (int i = 0; i < 200; i++) pool_item(8);
    settle();
    for (int i = 0; i < 200; i++) pool_item(8);
    settle();

    $display("covered %0d results: %0d cleanups, %0d hits, %0d expansions, %0d drops",
             n_results, n_cleans, n_hits, n_expands, n_drops);
    $display("thresholds 512, 1024, 0 and 37; limit grown to its top and shrunk back");
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
